[rtl/core/arpp_pkg.sv]
`default_nettype none

package arpp_pkg;

    // build-time sizing
    localparam int NUM_RANGES = 4;
    localparam int ADC_BITS   = 24;
    localparam int RANGE_W    = (NUM_RANGES > 2) ? $clog2(NUM_RANGES) : 1;

    // fixed field widths
    localparam int SAMPLE_W  = 24;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 24;
    localparam int PWR_W     = 49;
    localparam int HI_W      = 30;  // lane * 10000
    localparam int LO_W      = 23;  // lane * 100
    localparam int ADC_W     = 26;  // sample minus signed offset
    localparam int DIFF_W    = 27;  // adc minus signed intercept
    localparam int MAG_W     = 26;
    localparam int QUO_W     = MAG_W + 16;
    localparam int HALF_W    = QUO_W / 2;
    localparam int PROD_W    = HALF_W + GAIN_W;
    localparam int ACC_W     = QUO_W + GAIN_W;
    localparam int CNT_W     = $clog2(QUO_W);

    localparam logic [RANGE_W-1:0] LAST_RANGE = RANGE_W'(NUM_RANGES - 1);

    localparam logic [HI_W-1:0] HI_SCALE = HI_W'(10000);
    localparam logic [LO_W-1:0] LO_SCALE = LO_W'(100);

    localparam logic [PWR_W-1:0] PWR_MAX = {1'b0, {(PWR_W-1){1'b1}}};
    localparam logic [PWR_W-1:0] PWR_MIN = {1'b1, {(PWR_W-1){1'b0}}};

    localparam logic [CFG_W-1:0] HIGH_THR_RST = 64'd470070383811626630;
    localparam logic [CFG_W-1:0] LOW_THR_RST  = 64'd188941435436140166;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOPES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERCEPTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSETS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd5;

    localparam logic [3:0] SEL_PATTERN [4] = '{4'h7, 4'hD, 4'hB, 4'hE};

    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_RESAMPLE = 3'd1,
        ST_HIGH     = 3'd2,
        ST_LOW      = 3'd3,
        ST_NOSLOPE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0]  slopes;
        logic [CFG_W-1:0]  intercepts;
        logic [CFG_W-1:0]  offsets;
        logic [CFG_W-1:0]  high_thr;
        logic [CFG_W-1:0]  low_thr;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic    take;
        logic    limits;
        logic    move;
        logic    keep;
        logic    div_init;
        logic    div_step;
        logic    mul_lo;
        logic    mul_hi;
        logic    pwr;
        logic    out_load;
        t_status code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic move_req;
        logic adc_high;
        logic adc_low;
        logic slope_zero;
        logic div_last;
        logic pwr_nonpos;
    } t_stat;

    function automatic logic [15:0] lane16(input logic [CFG_W-1:0] word, input logic [1:0] idx);
        return word[{idx, 4'b0000} +: 16];
    endfunction

endpackage

`default_nettype wire

[rtl/core/arpp_cfg.sv]
`default_nettype none

module arpp_cfg
    import arpp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slopes     <= '0;
            r_cfg.intercepts <= '0;
            r_cfg.offsets    <= '0;
            r_cfg.high_thr   <= HIGH_THR_RST;
            r_cfg.low_thr    <= LOW_THR_RST;
            r_cfg.gain       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SLOPES:     r_cfg.slopes     <= i_cfg_data;
                REG_INTERCEPTS: r_cfg.intercepts <= i_cfg_data;
                REG_OFFSETS:    r_cfg.offsets    <= i_cfg_data;
                REG_HIGH_THR:   r_cfg.high_thr   <= i_cfg_data;
                REG_LOW_THR:    r_cfg.low_thr    <= i_cfg_data;
                REG_GAIN:       r_cfg.gain       <= i_cfg_data[GAIN_W-1:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/core/arpp_ctrl.sv]
`default_nettype none

module arpp_ctrl
    import arpp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LIMITS = 9'b000000010,
        S_RAW    = 9'b000000100,
        S_ADJ    = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_MUL_LO = 9'b000100000,
        S_MUL_HI = 9'b001000000,
        S_POWER  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_out_valid, n_out_valid;
    logic    out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.code  = r_code;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LIMITS;
                end
            end
            S_LIMITS: begin
                o_cmd.limits = 1'b1;
                n_state      = S_RAW;
            end
            S_RAW: begin
                if (i_stat.move_req) begin
                    o_cmd.move = 1'b1;
                    n_code     = ST_RESAMPLE;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.keep = 1'b1;
                    n_state    = S_ADJ;
                end
            end
            S_ADJ: begin
                if (i_stat.adc_high) begin
                    n_code  = ST_HIGH;
                    n_state = S_DONE;
                end else if (i_stat.adc_low) begin
                    n_code  = ST_LOW;
                    n_state = S_DONE;
                end else if (i_stat.slope_zero) begin
                    n_code  = ST_NOSLOPE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_POWER;
            end
            S_POWER: begin
                o_cmd.pwr = 1'b1;
                n_code    = i_stat.pwr_nonpos ? ST_LOW : ST_VALID;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_VALID;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/core/arpp_dpath.sv]
`default_nettype none

module arpp_dpath
    import arpp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [SAMPLE_W-1:0] i_adc_sample,
    input  wire t_cfg                i_cfg,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    output logic [2:0]               o_status,
    output logic [PWR_W-1:0]         o_power,
    output logic [1:0]               o_active_range,
    output logic [3:0]               o_range_select_lines,
    output logic [SAMPLE_W-1:0]      o_kept_sample
);

    // persistent state
    logic [RANGE_W-1:0]  r_range;
    logic [SAMPLE_W-1:0] r_kept;
    logic [PWR_W-1:0]    r_power;

    // per-item working registers
    logic [ADC_BITS-1:0]     r_sample;
    logic [HI_W-1:0]         r_hi;
    logic [LO_W-1:0]         r_lo;
    logic signed [ADC_W-1:0] r_adc;
    logic                    r_neg;
    logic [QUO_W-1:0]        r_dq;    // dividend shifts out, quotient shifts in
    logic [15:0]             r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic [ACC_W-1:0]        r_acc;

    // output register
    logic [2:0]          r_o_status;
    logic [PWR_W-1:0]    r_o_power;
    logic [1:0]          r_o_range;
    logic [3:0]          r_o_sel;
    logic [SAMPLE_W-1:0] r_o_kept;

    logic [1:0]              lane_idx;
    logic [15:0]             hi_lane, lo_lane, slope, off_lane, icpt_lane;
    logic [SAMPLE_W-1:0]     sample;
    logic                    raw_high, raw_low;
    logic signed [ADC_W-1:0] adc_next;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [16:0]             trial;
    logic                    trial_ge;
    logic [HALF_W-1:0]       mul_a;
    logic [PROD_W-1:0]       prod;
    logic [QUO_W+7:0]        q_pwr;   // acc >> 16
    logic                    frac_nz;
    logic [QUO_W+8:0]        neg_mag;
    logic [PWR_W-1:0]        pwr_next;

    assign lane_idx  = 2'(r_range);
    assign hi_lane   = lane16(i_cfg.high_thr, lane_idx);
    assign lo_lane   = lane16(i_cfg.low_thr, lane_idx);
    assign slope     = lane16(i_cfg.slopes, lane_idx);
    assign off_lane  = lane16(i_cfg.offsets, lane_idx);
    assign icpt_lane = lane16(i_cfg.intercepts, lane_idx);

    assign sample   = SAMPLE_W'(r_sample);
    assign raw_high = {(HI_W-SAMPLE_W)'(0), sample} >= r_hi;
    assign raw_low  = sample < SAMPLE_W'(r_lo);
    assign adc_next = signed'({2'b00, sample}) - ADC_W'(signed'(off_lane));

    // offset-corrected value is only compared when nonnegative
    assign o_stat.move_req   = raw_high ? (r_range != '0) : (raw_low && r_range != LAST_RANGE);
    assign o_stat.adc_high   = !r_adc[ADC_W-1] &&
                               ({(HI_W-ADC_W+1)'(0), r_adc[ADC_W-2:0]} >= r_hi);
    assign o_stat.adc_low    = r_adc[ADC_W-1] ||
                               (r_adc[ADC_W-2:0] < (ADC_W-1)'(r_lo));
    assign o_stat.slope_zero = (slope == '0);
    assign o_stat.div_last   = (r_cnt == CNT_W'(QUO_W - 1));

    assign diff = DIFF_W'(r_adc) - DIFF_W'(signed'(icpt_lane));
    assign mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    // restoring divide, one quotient bit per cycle
    assign trial    = {r_rem, r_dq[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, slope};

    // quotient magnitude times gain in two halves
    assign mul_a = i_cmd.mul_hi ? r_dq[QUO_W-1:HALF_W] : r_dq[HALF_W-1:0];
    assign prod  = PROD_W'(mul_a) * PROD_W'(i_cfg.gain);

    // floor of signed product / 2^16, saturated
    assign q_pwr   = r_acc[ACC_W-1:16];
    assign frac_nz = |r_acc[15:0];
    assign neg_mag = {1'b0, q_pwr} + (QUO_W+9)'(frac_nz);

    always_comb begin
        if (!r_neg) begin
            pwr_next = (q_pwr[QUO_W+7:PWR_W-1] != '0) ? PWR_MAX : PWR_W'(q_pwr);
        end else if (neg_mag > (QUO_W+9)'(PWR_MIN)) begin
            pwr_next = PWR_MIN;
        end else begin
            pwr_next = PWR_W'(-neg_mag);
        end
    end

    assign o_stat.pwr_nonpos = r_neg || (q_pwr == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= '0;
            r_kept  <= '0;
            r_power <= '0;
        end else begin
            if (i_cmd.move) begin
                r_range <= raw_high ? r_range - 1'b1 : r_range + 1'b1;
            end
            if (i_cmd.keep) begin
                r_kept <= sample;
            end
            if (i_cmd.pwr) begin
                r_power <= pwr_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_adc_sample[ADC_BITS-1:0];
        end
        if (i_cmd.limits) begin
            r_hi <= {(HI_W-16)'(0), hi_lane} * HI_SCALE;
            r_lo <= {(LO_W-16)'(0), lo_lane} * LO_SCALE;
        end
        if (i_cmd.keep) begin
            r_adc <= adc_next;
        end
        if (i_cmd.div_init) begin
            r_neg <= diff[DIFF_W-1];
            r_dq  <= {mag, 16'h0000};
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? 16'(trial - {1'b0, slope}) : 16'(trial);
            r_dq  <= {r_dq[QUO_W-2:0], trial_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.mul_lo) begin
            r_acc <= ACC_W'(prod);
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + ACC_W'({prod, HALF_W'(0)});
        end
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.code;
            r_o_power  <= r_power;
            r_o_range  <= 2'(r_range);
            r_o_sel    <= SEL_PATTERN[lane_idx];
            r_o_kept   <= r_kept;
        end
    end

    assign o_status             = r_o_status;
    assign o_power              = r_o_power;
    assign o_active_range       = r_o_range;
    assign o_range_select_lines = r_o_sel;
    assign o_kept_sample        = r_o_kept;

endmodule

`default_nettype wire

[rtl/core/autorange_photodiode_power.sv]
// One request in flight: a kept sample with a nonzero slope runs limits, range check,
// offset check, bit-serial divide, split multiply and power; a resample or a
// threshold/zero-slope exit goes straight to the result. The next request is taken once
// the result has entered the output register.
// Reset (sync, active low): range 0, kept sample and power 0, config to defaults.
`default_nettype none

module autorange_photodiode_power
    import arpp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // sample request
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [SAMPLE_W-1:0]  i_adc_sample,
    // result
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [2:0]                o_status,
    output logic [PWR_W-1:0]          o_power,
    output logic [1:0]                o_active_range,
    output logic [3:0]                o_range_select_lines,
    output logic [SAMPLE_W-1:0]       o_kept_sample
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    // Config registers: thresholds, slopes, intercepts, offsets, gain.
    arpp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Sequencer: limits, raw range check, offset check, divide, multiply, power.
    // The output register frees the input side, so a new request is taken
    // while the previous result is still waiting downstream.
    arpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: range state, restoring divider, split gain multiply,
    // floor/saturate of power, output register.
    arpp_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_adc_sample         (i_adc_sample),
        .i_cfg                (cfg),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .o_status             (o_status),
        .o_power              (o_power),
        .o_active_range       (o_active_range),
        .o_range_select_lines (o_range_select_lines),
        .o_kept_sample        (o_kept_sample)
    );

endmodule

`default_nettype wire
